// ----- rtl/sia_pkg.sv -----
package sia_pkg;

	localparam int Slots     = 32;
	localparam int SlotBits  = $clog2(Slots);
	localparam int IdentBits = 27;
	localparam int UsageBits = 20;
	// identifier = slot in the upper bits, generation below
	localparam int GenBits   = IdentBits - SlotBits;

	typedef enum logic [2:0] {
		OP_ALLOC    = 3'd0,
		OP_COMMIT   = 3'd1,
		OP_ABORT    = 3'd2,
		OP_DESTROY  = 3'd3,
		OP_LOOKUP   = 3'd4,
		OP_SIZE_INC = 3'd5,
		OP_SIZE_DEC = 3'd6
	} op_e;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_FREE  = 2'd1,
		ST_NO_MATCH = 2'd2,
		ST_NOT_INIT = 2'd3
	} status_e;

	typedef struct packed {
		status_e                status;
		logic [IdentBits-1:0]   new_ident;
		logic                   alive;
		logic [UsageBits-1:0]   usage;
	} result_t;

endpackage

// ----- rtl/sia_slot_table.sv -----
module sia_slot_table (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           fire,
	input  logic [2:0]                     opcode,
	input  logic [sia_pkg::IdentBits-1:0]  ident,
	output sia_pkg::result_t               result
);

	localparam int Slots     = sia_pkg::Slots;
	localparam int SlotBits  = sia_pkg::SlotBits;
	localparam int IdentBits = sia_pkg::IdentBits;
	localparam int UsageBits = sia_pkg::UsageBits;
	localparam int GenBits   = sia_pkg::GenBits;
	localparam logic [SlotBits:0] NoSlot = (SlotBits+1)'(Slots);

	// per-slot state
	logic [Slots-1:0]     occupied_q;
	logic [Slots-1:0]     initialised_q;
	logic [GenBits-1:0]   occ_gen_q  [Slots];
	logic [GenBits-1:0]   next_gen_q [Slots];
	logic [UsageBits-1:0] usage_q    [Slots];
	logic [SlotBits:0]    free_next_q [Slots];
	logic [SlotBits:0]    free_head_q;

	sia_pkg::op_e         op;
	logic [SlotBits-1:0]  addr;
	logic                 head_ok;
	logic                 match;
	logic                 do_alloc;
	logic                 do_release;
	logic                 set_init;
	logic                 wr_usage;
	logic [UsageBits-1:0] usage_rd;
	logic [UsageBits-1:0] usage_new;

	always_comb begin
		op       = sia_pkg::op_e'(opcode);
		head_ok  = free_head_q != NoSlot;
		// alloc works on the list head, everything else on the slot in the ident
		addr     = (op == sia_pkg::OP_ALLOC) ? free_head_q[SlotBits-1:0]
		                                     : ident[IdentBits-1 -: SlotBits];
		match    = occupied_q[addr] && (occ_gen_q[addr] == ident[GenBits-1:0]);
		usage_rd = usage_q[addr];

		do_alloc   = 1'b0;
		do_release = 1'b0;
		set_init   = 1'b0;
		wr_usage   = 1'b0;
		usage_new  = usage_rd;

		result.status    = sia_pkg::ST_OK;
		result.new_ident = '0;
		result.alive     = 1'b0;
		result.usage     = '0;

		if (op == sia_pkg::OP_ALLOC) begin
			if (!head_ok) begin
				result.status = sia_pkg::ST_NO_FREE;
			end else begin
				do_alloc         = 1'b1;
				result.new_ident = {addr, next_gen_q[addr]};
				result.alive     = 1'b1;
			end
		end else if (!match) begin
			result.status = sia_pkg::ST_NO_MATCH;
		end else begin
			result.alive = 1'b1;
			unique case (op)
				sia_pkg::OP_COMMIT: begin
					set_init = 1'b1;
				end
				sia_pkg::OP_ABORT: begin
					do_release = 1'b1;
				end
				sia_pkg::OP_DESTROY: begin
					if (!initialised_q[addr]) begin
						result.status = sia_pkg::ST_NOT_INIT;
					end else begin
						do_release = 1'b1;
					end
				end
				sia_pkg::OP_SIZE_INC: begin
					if (usage_rd != '1) begin
						usage_new = usage_rd + 1'b1;
						wr_usage  = 1'b1;
					end
				end
				sia_pkg::OP_SIZE_DEC: begin
					if (usage_rd != '0) begin
						usage_new = usage_rd - 1'b1;
						wr_usage  = 1'b1;
					end
				end
				default: begin
				end
			endcase
			result.usage = usage_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occupied_q    <= '0;
			initialised_q <= '0;
			free_head_q   <= '0;
			for (int i = 0; i < Slots; i++) begin
				free_next_q[i] <= (SlotBits+1)'(i + 1);
				next_gen_q[i]  <= '0;
			end
		end else if (fire) begin
			if (do_alloc) begin
				occupied_q[addr]    <= 1'b1;
				initialised_q[addr] <= 1'b0;
				next_gen_q[addr]    <= next_gen_q[addr] + 1'b1;
				free_head_q         <= free_next_q[addr];
				free_next_q[addr]   <= NoSlot;
			end
			if (do_release) begin
				occupied_q[addr]    <= 1'b0;
				initialised_q[addr] <= 1'b0;
				free_next_q[addr]   <= free_head_q;
				free_head_q         <= {1'b0, addr};
			end
			if (set_init) begin
				initialised_q[addr] <= 1'b1;
			end
		end
	end

	// generation tag and usage count only matter while the slot is occupied
	always_ff @(posedge clk) begin
		if (fire && do_alloc) begin
			occ_gen_q[addr] <= next_gen_q[addr];
			usage_q[addr]   <= '0;
		end else if (fire && wr_usage) begin
			usage_q[addr] <= usage_new;
		end
	end

`ifndef SYNTH
	a_alloc_marks_slot: assert property (@(posedge clk) disable iff (!arst_n)
		fire && do_alloc |=> occupied_q[$past(addr)] && !initialised_q[$past(addr)])
		else $error("allocated slot not marked occupied");

	a_head_is_free: assert property (@(posedge clk) disable iff (!arst_n)
		free_head_q != NoSlot |-> !occupied_q[free_head_q[SlotBits-1:0]])
		else $error("free list head points at an occupied slot");

	a_release_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		fire && do_release |=> free_head_q == {1'b0, $past(addr)}
		&& !occupied_q[$past(addr)])
		else $error("released slot not pushed on free list");
`endif

endmodule

// ----- rtl/slot_id_allocator_with_generation_top.sv -----
// Items pass the input register, then the result register. Throughput: one item per
// cycle while results drain; each item is a single read-modify-write of one slot
// entry plus the free-list head, done between the input and result registers.
// Reset (arst_n, async, active low): pipeline empties, free list returns to
// slots 0, 1, 2, ... in order, generations to zero, all slots free. No clearing pass.
module slot_id_allocator_with_generation_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [2:0]                     opcode,
	input  logic [sia_pkg::IdentBits-1:0]  ident,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [1:0]                     status,
	output logic [sia_pkg::IdentBits-1:0]  new_ident,
	output logic                           alive,
	output logic [sia_pkg::UsageBits-1:0]  usage
);

	// input register
	logic                          valid_s1;
	logic [2:0]                    opcode_s1;
	logic [sia_pkg::IdentBits-1:0] ident_s1;

	// result register
	logic                          out_valid_q;
	sia_pkg::result_t              res_q;
	sia_pkg::result_t              res;

	logic accept;
	logic advance;

	// the item in the input register moves on (and updates the table) when the
	// result register is empty or being drained this cycle
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_s1 <= opcode;
			ident_s1  <= ident;
		end
	end

	// table state and per-item operation
	sia_slot_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.opcode (opcode_s1),
		.ident  (ident_s1),
		.result (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = res_q.status;
	assign new_ident = res_q.new_ident;
	assign alive     = res_q.alive;
	assign usage     = res_q.usage;

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import sia_pkg::*;

	// free list terminator, as the block encodes it
	localparam int NoSlot = Slots;
	// generous for ~1900 items with random sender and receiver idling
	localparam int CycleLimit = 400000;
	// opcode outside the enum; the block must treat it as a lookup
	localparam logic [2:0] OpUnused = 3'd7;
	localparam int ReportLimit = 10;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [2:0] opcode;
	logic [IdentBits-1:0] ident;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	logic [IdentBits-1:0] new_ident;
	logic alive;
	logic [UsageBits-1:0] usage;

	slot_id_allocator_with_generation_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.opcode    (opcode),
		.ident     (ident),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.new_ident (new_ident),
		.alive     (alive),
		.usage     (usage)
	);

	// ------------------------------------------------------------------
	// Slot table mirror: free list, generations, per-slot entry state
	// ------------------------------------------------------------------
	int                   fl_head;
	int                   fl_link    [Slots];
	logic [IdentBits-1:0] gen_next   [Slots];
	logic [IdentBits-1:0] slot_ident [Slots];
	bit                   slot_busy  [Slots];
	bit                   slot_ready [Slots];
	logic [UsageBits-1:0] slot_use   [Slots];

	// results owed by the block, oldest first
	result_t results_due[$];
	result_t want;
	logic [IdentBits-1:0] last_new;

	int cycles = 0;
	int fails = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_alloc = 0;
	int n_refused = 0;
	int n_freed = 0;
	int status_seen [4] = '{0, 0, 0, 0};

	// idling knobs
	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;
	bit rx_hold = 1'b0;
	int rx_left = 0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
	end

	// watchdog
	initial begin
		while (cycles < CycleLimit) @(posedge clk);
		$display("timeout after %0d cycles, %0d results still owed",
			cycles, results_due.size());
		$display("Regression FAIL");
		$finish;
	end

	task automatic reset_table();
		int i;
		fl_head = 0;
		for (i = 0; i < Slots; i++) begin
			fl_link[i]    = i + 1;
			gen_next[i]   = IdentBits'(i) << GenBits;
			slot_ident[i] = '0;
			slot_busy[i]  = 1'b0;
			slot_ready[i] = 1'b0;
			slot_use[i]   = '0;
		end
		fl_link[Slots-1] = NoSlot;
	endtask

	// return a slot to the head of the free list
	task automatic release_entry(input int s);
		slot_busy[s]  = 1'b0;
		slot_ready[s] = 1'b0;
		fl_link[s]    = fl_head;
		fl_head       = s;
		n_freed++;
	endtask

	// Apply one accepted operation to the mirror and queue the result it owes.
	task automatic apply_table_op(input logic [2:0] op, input logic [IdentBits-1:0] id);
		result_t r;
		int s;
		logic [SlotBits-1:0] slot_sel;
		logic [GenBits-1:0] gen;
		r = '0;
		r.status = ST_OK;
		if (op == OP_ALLOC) begin
			n_alloc++;
			if (fl_head == NoSlot) begin
				r.status = ST_NO_FREE;
				n_refused++;
			end else begin
				s = fl_head;
				slot_sel = SlotBits'(s);
				slot_busy[s]  = 1'b1;
				slot_ready[s] = 1'b0;
				slot_use[s]   = '0;
				slot_ident[s] = gen_next[s];
				// generation wraps within its own field, slot bits stay put
				gen = slot_ident[s][GenBits-1:0] + 1'b1;
				gen_next[s] = {slot_sel, gen};
				fl_head    = fl_link[s];
				fl_link[s] = NoSlot;
				r.new_ident = slot_ident[s];
				r.alive = 1'b1;
				last_new = slot_ident[s];
			end
		end else begin
			// slot index is the upper ident bits; always in range at this size
			slot_sel = id[IdentBits-1:GenBits];
			s = slot_sel;
			if (!slot_busy[s] || slot_ident[s] != id) begin
				r.status = ST_NO_MATCH;
			end else begin
				r.alive = 1'b1;
				case (op)
					OP_COMMIT: begin
						slot_ready[s] = 1'b1;
					end
					OP_ABORT: begin
						release_entry(s);
					end
					OP_DESTROY: begin
						if (!slot_ready[s]) r.status = ST_NOT_INIT;
						else release_entry(s);
					end
					OP_SIZE_INC: begin
						if (slot_use[s] != '1) slot_use[s] = slot_use[s] + 1'b1;
					end
					OP_SIZE_DEC: begin
						if (slot_use[s] != '0) slot_use[s] = slot_use[s] - 1'b1;
					end
					default: begin
					end
				endcase
				// a freed entry still reports the count it held
				r.usage = slot_use[s];
			end
		end
		status_seen[r.status]++;
		n_sent++;
		results_due.push_back(r);
	endtask

	// ------------------------------------------------------------------
	// Sender: offer one item, hold it until taken, then update the mirror.
	// The mirror is updated at the accepting edge, so the next item can
	// already target the identifier this one handed out.
	// ------------------------------------------------------------------
	task automatic send_item(input logic [2:0] op, input logic [IdentBits-1:0] id);
		if (tx_idle && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= op;
		ident    <= id;
		do @(posedge clk); while (in_stall);
		apply_table_op(op, id);
	endtask

	// ------------------------------------------------------------------
	// Receiver: random stall bursts, or a forced hold-off
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (rx_hold) begin
			out_stall <= 1'b1;
		end else if (rx_left != 0) begin
			out_stall <= 1'b1;
			rx_left <= rx_left - 1;
		end else if (rx_idle && $urandom_range(0, 7) == 0) begin
			out_stall <= 1'b1;
			rx_left <= $urandom_range(0, 13);
		end else begin
			out_stall <= 1'b0;
		end
	end

	task automatic flag_mismatch(input string what, input longint want_v, input longint got_v);
		fails++;
		if (fails <= ReportLimit)
			$display("mismatch on %s at cycle %0d: expected %0h, got %0h",
				what, cycles, want_v, got_v);
	endtask

	// ------------------------------------------------------------------
	// Result check: each taken result against the oldest owed one
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (results_due.size() == 0) begin
				flag_mismatch("result with none owed", -1, status);
			end else begin
				want = results_due.pop_front();
				n_checked++;
				if (status !== want.status) flag_mismatch("status", want.status, status);
				if (new_ident !== want.new_ident)
					flag_mismatch("new_ident", want.new_ident, new_ident);
				if (alive !== want.alive) flag_mismatch("alive", want.alive, alive);
				if (usage !== want.usage) flag_mismatch("usage", want.usage, usage);
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// Mostly a live identifier, sometimes a stale generation, sometimes noise.
	function automatic logic [IdentBits-1:0] pick_target();
		int busy[$];
		int i;
		int t;
		t = $urandom_range(0, 9);
		for (i = 0; i < Slots; i++)
			if (slot_busy[i]) busy.push_back(i);
		if (t <= 6 && busy.size() != 0)
			return slot_ident[busy[$urandom_range(0, busy.size() - 1)]];
		if (t <= 7)
			return gen_next[$urandom_range(0, Slots - 1)] - 1'b1;
		return IdentBits'($urandom());
	endfunction

	task automatic send_random(input int alloc_pct);
		logic [2:0] op;
		if ($urandom_range(0, 99) < alloc_pct) begin
			// ident is don't-care for alloc; drive noise there
			send_item(OP_ALLOC, IdentBits'($urandom()));
		end else begin
			case ($urandom_range(0, 5))
				0: op = OP_COMMIT;
				1: op = OP_ABORT;
				2: op = OP_DESTROY;
				3: op = OP_LOOKUP;
				4: op = OP_SIZE_INC;
				default: op = OP_SIZE_DEC;
			endcase
			send_item(op, pick_target());
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Lifecycle corners on a fresh table: first idents, commit twice,
	// usage floor, destroy before commit, stale and foreign idents,
	// unused opcode, LIFO reuse with a bumped generation.
	task automatic test_lifecycle();
		logic [IdentBits-1:0] id_a;
		logic [IdentBits-1:0] id_b;
		logic [IdentBits-1:0] id_c;
		send_item(OP_ALLOC, '1);
		id_a = last_new;
		send_item(OP_ALLOC, '0);
		id_b = last_new;
		send_item(OP_ALLOC, IdentBits'($urandom()));
		id_c = last_new;
		send_item(OP_LOOKUP, id_a);
		send_item(OP_COMMIT, id_a);
		send_item(OP_COMMIT, id_a);
		send_item(OP_SIZE_DEC, id_b);
		send_item(OP_SIZE_INC, id_b);
		send_item(OP_SIZE_INC, id_b);
		send_item(OP_SIZE_DEC, id_b);
		send_item(OP_DESTROY, id_b);
		send_item(OP_LOOKUP, '1);
		send_item(OpUnused, id_a);
		send_item(OP_LOOKUP, id_a + 1'b1);
		send_item(OP_ABORT, id_b);
		send_item(OP_DESTROY, id_a);
		send_item(OP_DESTROY, id_a);
		send_item(OP_ABORT, id_a);
		send_item(OP_ALLOC, '0);
		send_item(OP_ALLOC, '0);
		send_item(OP_SIZE_INC, id_b);
		send_item(OP_COMMIT, id_c);
		send_item(OP_DESTROY, id_c);
	endtask

	// Fill the table to the last slot, get refused, then empty it again.
	task automatic test_exhaust_table();
		int s;
		logic [IdentBits-1:0] id;
		while (fl_head != NoSlot) send_item(OP_ALLOC, IdentBits'($urandom()));
		send_item(OP_ALLOC, '0);
		send_item(OP_ALLOC, '1);
		for (s = 0; s < Slots; s++) begin
			if (slot_busy[s]) begin
				id = slot_ident[s];
				if ($urandom_range(0, 1) == 0) begin
					send_item(OP_COMMIT, id);
					send_item(OP_DESTROY, id);
				end else begin
					send_item(OP_SIZE_INC, id);
					send_item(OP_ABORT, id);
				end
			end
		end
	endtask

	// Receiver holds off for a long stretch while the sender keeps going,
	// so results back up and the block has to stall its input.
	task automatic test_backpressure();
		int i;
		tx_idle = 1'b0;
		fork
			begin
				rx_hold <= 1'b1;
				repeat (80) @(posedge clk);
				rx_hold <= 1'b0;
			end
		join_none
		for (i = 0; i < 40; i++) send_random(35);
		tx_idle = 1'b1;
	endtask

	// Bulk random traffic; the alloc share swings so the table keeps
	// running full and draining empty.
	task automatic test_random_mix(input int count);
		int i;
		for (i = 0; i < count; i++)
			send_random(((i / 120) % 2 == 0) ? 55 : 15);
	endtask

	// Last stretch at full rate on both sides.
	task automatic test_full_rate(input int count);
		int i;
		tx_idle = 1'b0;
		rx_idle <= 1'b0;
		for (i = 0; i < count; i++) send_random(40);
	endtask

	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		opcode   = OP_LOOKUP;
		ident    = '0;
		reset_table();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_lifecycle();
		test_exhaust_table();
		test_backpressure();
		test_random_mix(1500);
		test_full_rate(200);

		in_valid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		// a few more edges catch any stray result
		repeat (8) @(posedge clk);

		$display("Covered %0d items (%0d checked): %0d allocs, %0d refused, %0d frees.",
			n_sent, n_checked, n_alloc, n_refused, n_freed);
		$display("Statuses ok/full/no-match/not-init: %0d/%0d/%0d/%0d, one long stall.",
			status_seen[ST_OK], status_seen[ST_NO_FREE], status_seen[ST_NO_MATCH],
			status_seen[ST_NOT_INIT]);
		if (fails == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
